FILE: sv/spat_pkg.sv
// spat_pkg: shared codes, widths and types of the segmented paged address translator
// used by spat_ctrl, spat_datapath and segmented_paged_address_translator_core
package spat_pkg;

  // parameter defaults
  localparam int SEG_ENTRIES_DEF   = 16;
  localparam int PAGES_PER_SEG_DEF = 64;

  // stream payload widths
  localparam int S_TDATA_W = 136;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 168;
  localparam int M_TUSER_W = 2;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_SIZE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE = 1'd1;

  // field limits of the address split
  localparam logic [3:0] SEG_SIZE_MAX  = 4'd12;
  localparam logic [4:0] PAGE_SIZE_MAX = 5'd22;
  localparam logic [4:0] SEG_BITS_MAX  = 5'd12;
  localparam logic [4:0] ID_BITS       = 5'd22;
  localparam logic [5:0] ADDR_BITS     = 6'd32;
  localparam logic [5:0] PAGE_KB_SHIFT = 6'd10;

  // function codes carried in the input tuser
  localparam logic [1:0] FN_SEG_WR = 2'd0;
  localparam logic [1:0] FN_PG_WR  = 2'd1;
  localparam logic [1:0] FN_XLATE  = 2'd2;
  localparam logic [1:0] FN_NOP    = 2'd3;

  // result status codes carried in the output tuser
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_SEG_FAULT  = 2'd1;
  localparam logic [1:0] ST_PAGE_FAULT = 2'd2;
  localparam logic [1:0] ST_WRITE_DONE = 2'd3;

  // segment table entry
  typedef struct packed {
    logic [11:0] num;
    logic [31:0] len;
  } seg_entry_t;

  // page table entry, valid flag kept in the memory word
  typedef struct packed {
    logic        valid;
    logic [21:0] page;
    logic [21:0] frame;
  } pg_entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic       capture;
    logic       clr_step;
    logic       srch_step;
    logic       pg_start;
    logic       pg_take;
    logic       load_out;
    logic [1:0] status;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic in_xlate;
    logic cmp_vld;
    logic cmp_last;
    logic seg_hit;
    logic seg_len_ok;
    logic pg_hit;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/segmented_paged_address_translator_core.sv
// Segmented paged address translator. Each input transaction writes a segment entry, writes a
// page entry, translates a 32-bit logical address or is a no-op; each yields exactly one result.
// A write goes from acceptance to the finish state and then into the output register once
// that is free. A translation searches the segment table one slot a cycle and then the chosen
// segment's page table one slot a cycle, through a single registered-read port on each table,
// and stops early when a slot matches. One transaction is in work at a time; the output
// register holds a finished result while the next one is accepted.
// After reset the page table memory is swept clear, one entry a cycle, over all
// SEG_ENTRIES * PAGES_PER_SEG entries (1024 at the defaults); input tready stays low meanwhile,
// configuration writes are taken at any time. Configure only while the block is idle.
// depends on spat_pkg, spat_ctrl and spat_datapath
module segmented_paged_address_translator_core #(
  parameter int SEG_ENTRIES   = spat_pkg::SEG_ENTRIES_DEF,
  parameter int PAGES_PER_SEG = spat_pkg::PAGES_PER_SEG_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [spat_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [spat_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // input stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // seg_slot[3:0] page_slot[9:4] entry_valid[10] seg_id[22:11] seg_limit[54:23]
  // page_id[76:55] frame_id[98:77] logical_addr[130:99], zero above
  input  logic [spat_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // func[1:0]
  input  logic [spat_pkg::S_TUSER_W-1:0]   s_axis_tuser_i,
  // output stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // seg_field[11:0] seg_offset[43:12] page_field[65:44] page_offset[97:66]
  // frame_base[129:98] phys_addr[161:130], zero above
  output logic [spat_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // status[1:0]
  output logic [spat_pkg::M_TUSER_W-1:0]   m_axis_tuser_o
);

  spat_pkg::cmd_t cmd;
  spat_pkg::sts_t sts;

  // sequencer
  spat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // tables and arithmetic
  spat_datapath #(
    .SEG_ENTRIES   (SEG_ENTRIES),
    .PAGES_PER_SEG (PAGES_PER_SEG)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

FILE: sv/spat_ctrl.sv
// spat_ctrl: sequencer of the address translator (clear pass, searches, result hand-off)
// depends on spat_pkg for the command and status structs and the status codes
module spat_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output spat_pkg::cmd_t    cmd_o,
  input  spat_pkg::sts_t    sts_i
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SEG    = 3'd2;
  localparam logic [2:0] S_PAGE   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_q, state_d;
  logic [1:0] res_q, res_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.status = res_q;
    in_ready_o   = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (sts_i.in_xlate) begin
            state_d = S_SEG;
          end else begin
            res_d   = spat_pkg::ST_WRITE_DONE;
            state_d = S_FINISH;
          end
        end
      end
      S_SEG: begin
        cmd_o.srch_step = 1'b1;
        if (sts_i.cmp_vld && sts_i.seg_hit) begin
          if (sts_i.seg_len_ok) begin
            cmd_o.pg_start = 1'b1;
            state_d = S_PAGE;
          end else begin
            res_d   = spat_pkg::ST_SEG_FAULT;
            state_d = S_FINISH;
          end
        end else if (sts_i.cmp_vld && sts_i.cmp_last) begin
          res_d   = spat_pkg::ST_SEG_FAULT;
          state_d = S_FINISH;
        end
      end
      S_PAGE: begin
        cmd_o.srch_step = 1'b1;
        if (sts_i.cmp_vld && sts_i.pg_hit) begin
          cmd_o.pg_take = 1'b1;
          res_d   = spat_pkg::ST_OK;
          state_d = S_FINISH;
        end else if (sts_i.cmp_vld && sts_i.cmp_last) begin
          res_d   = spat_pkg::ST_PAGE_FAULT;
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      res_q   <= spat_pkg::ST_WRITE_DONE;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

endmodule

FILE: sv/spat_datapath.sv
// spat_datapath: tables, address split, search counter and output register
// depends on spat_pkg for entry types, codes and command and status structs
module spat_datapath #(
  parameter int SEG_ENTRIES   = spat_pkg::SEG_ENTRIES_DEF,
  parameter int PAGES_PER_SEG = spat_pkg::PAGES_PER_SEG_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [spat_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [spat_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [spat_pkg::S_TDATA_W-1:0]   in_data_i,
  input  logic [spat_pkg::S_TUSER_W-1:0]   in_user_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [spat_pkg::M_TDATA_W-1:0]   out_data_o,
  output logic [spat_pkg::M_TUSER_W-1:0]   out_user_o,
  input  spat_pkg::cmd_t                   cmd_i,
  output spat_pkg::sts_t                   sts_o
);

  localparam int PAGE_TOTAL = SEG_ENTRIES * PAGES_PER_SEG;
  localparam int SEG_AW     = (SEG_ENTRIES > 1) ? $clog2(SEG_ENTRIES) : 1;
  localparam int PSL_W      = (PAGES_PER_SEG > 1) ? $clog2(PAGES_PER_SEG) : 1;
  localparam int PG_AW      = (PAGE_TOTAL > 1) ? $clog2(PAGE_TOTAL) : 1;
  localparam int CNT_MAX    = (SEG_ENTRIES > PAGES_PER_SEG) ? SEG_ENTRIES : PAGES_PER_SEG;
  localparam int CNT_W      = $clog2(CNT_MAX + 1);
  localparam logic [CNT_W-1:0] SEG_LIM  = CNT_W'(SEG_ENTRIES);
  localparam logic [CNT_W-1:0] PG_LIM   = CNT_W'(PAGES_PER_SEG);
  localparam logic [CNT_W-1:0] SEG_LAST = CNT_W'(SEG_ENTRIES - 1);
  localparam logic [CNT_W-1:0] PG_LAST  = CNT_W'(PAGES_PER_SEG - 1);
  localparam logic [PG_AW-1:0] CLR_LAST = PG_AW'(PAGE_TOTAL - 1);
  localparam logic [PG_AW-1:0] PG_STRIDE = PG_AW'(PAGES_PER_SEG);

  // input fields
  logic [3:0]  in_seg_slot;
  logic [5:0]  in_page_slot;
  logic        in_entry_valid;
  logic [11:0] in_seg_id;
  logic [31:0] in_seg_limit;
  logic [21:0] in_page_id;
  logic [21:0] in_frame_id;
  logic [31:0] in_logical_addr;

  assign in_seg_slot     = in_data_i[3:0];
  assign in_page_slot    = in_data_i[9:4];
  assign in_entry_valid  = in_data_i[10];
  assign in_seg_id       = in_data_i[22:11];
  assign in_seg_limit    = in_data_i[54:23];
  assign in_page_id      = in_data_i[76:55];
  assign in_frame_id     = in_data_i[98:77];
  assign in_logical_addr = in_data_i[130:99];

  // configuration registers
  logic [3:0] cfg_seg_q;
  logic [4:0] cfg_pg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_seg_q <= 4'd0;
      cfg_pg_q  <= 5'd2;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == spat_pkg::CFG_SEG_SIZE) begin
        cfg_seg_q <= cfg_wdata_i[3:0];
      end else if (cfg_idx_i == spat_pkg::CFG_PAGE_SIZE) begin
        cfg_pg_q <= cfg_wdata_i;
      end
    end
  end

  // captured address of the transaction under translation
  logic [31:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q <= in_logical_addr;
    end
  end

  // address split
  logic [3:0]  sz;
  logic [4:0]  pg;
  logic [4:0]  sbits;
  logic [4:0]  pbits;
  logic [5:0]  soff_w;
  logic [5:0]  obits;
  logic [11:0] sfield;
  logic [31:0] soff;
  logic [21:0] pfield;
  logic [31:0] poff;
  logic [31:0] sfield_w;
  logic [31:0] pfield_w;

  always_comb begin
    sz    = (cfg_seg_q > spat_pkg::SEG_SIZE_MAX) ? spat_pkg::SEG_SIZE_MAX : cfg_seg_q;
    pg    = (cfg_pg_q > spat_pkg::PAGE_SIZE_MAX) ? spat_pkg::PAGE_SIZE_MAX : cfg_pg_q;
    sbits = spat_pkg::SEG_BITS_MAX - {1'b0, sz};
    // the sum reaches 34, so it is taken one bit wider
    pbits = (({1'b0, sbits} + {1'b0, pg}) >= {1'b0, spat_pkg::ID_BITS}) ? 5'd0
            : (spat_pkg::ID_BITS - sbits - pg);
    soff_w   = spat_pkg::ADDR_BITS - {1'b0, sbits};
    obits    = soff_w - {1'b0, pbits};
    sfield_w = addr_q >> soff_w;
    sfield   = sfield_w[11:0];
    soff     = addr_q & ~(32'hFFFF_FFFF << soff_w);
    pfield_w = soff >> obits;
    pfield   = pfield_w[21:0];
    poff     = addr_q & ~(32'hFFFF_FFFF << obits);
  end

  // write decode
  logic seg_wr;
  logic pg_wr;

  assign seg_wr = cmd_i.capture && (in_user_i == spat_pkg::FN_SEG_WR)
                  && (int'(in_seg_slot) < SEG_ENTRIES);
  assign pg_wr  = cmd_i.capture && (in_user_i == spat_pkg::FN_PG_WR)
                  && (int'(in_seg_slot) < SEG_ENTRIES)
                  && (int'(in_page_slot) < PAGES_PER_SEG);

  // search counter and compare stage
  logic [CNT_W-1:0]  rd_cnt_q;
  logic [CNT_W-1:0]  cmp_idx_q;
  logic              cmp_vld_q;
  logic              pg_phase_q;
  logic [SEG_AW-1:0] seg_sel_q;
  logic [CNT_W-1:0]  lim;
  logic              rd_en;

  assign lim   = pg_phase_q ? PG_LIM : SEG_LIM;
  assign rd_en = cmd_i.srch_step && !cmd_i.pg_start && (rd_cnt_q < lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q   <= '0;
      cmp_vld_q  <= 1'b0;
      pg_phase_q <= 1'b0;
    end else begin
      priority if (cmd_i.capture) begin
        rd_cnt_q   <= '0;
        cmp_vld_q  <= 1'b0;
        pg_phase_q <= 1'b0;
      end else if (cmd_i.pg_start) begin
        rd_cnt_q   <= '0;
        cmp_vld_q  <= 1'b0;
        pg_phase_q <= 1'b1;
      end else if (cmd_i.srch_step) begin
        cmp_vld_q <= rd_en;
        if (rd_en) begin
          rd_cnt_q <= rd_cnt_q + CNT_W'(1);
        end
      end else begin
        cmp_vld_q <= 1'b0;
      end
    end
  end

  // index of the entry being compared and the matching segment
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      cmp_idx_q <= rd_cnt_q;
    end
    if (cmd_i.pg_start) begin
      seg_sel_q <= cmp_idx_q[SEG_AW-1:0];
    end
  end

  // segment table: valid bits in flops, entries in memory
  logic [SEG_ENTRIES-1:0]   seg_vld_q;
  spat_pkg::seg_entry_t     seg_mem [SEG_ENTRIES];
  spat_pkg::seg_entry_t     seg_rd_q;
  spat_pkg::seg_entry_t     seg_wdata;
  logic [SEG_AW-1:0]        seg_waddr;

  assign seg_wdata = '{num: in_seg_id, len: in_seg_limit};
  assign seg_waddr = SEG_AW'(in_seg_slot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_vld_q <= '0;
    end else if (seg_wr) begin
      seg_vld_q[seg_waddr] <= in_entry_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_wr) begin
      seg_mem[seg_waddr] <= seg_wdata;
    end
    if (rd_en && !pg_phase_q) begin
      seg_rd_q <= seg_mem[rd_cnt_q[SEG_AW-1:0]];
    end
  end

  // page table memory, cleared by a sweep after reset
  spat_pkg::pg_entry_t pg_mem [PAGE_TOTAL];
  spat_pkg::pg_entry_t pg_rd_q;
  spat_pkg::pg_entry_t pg_wdata;
  logic [PG_AW-1:0]    pg_waddr;
  logic [PG_AW-1:0]    pg_raddr;
  logic [PG_AW-1:0]    clr_q;
  logic                pg_we;

  assign pg_we    = pg_wr || cmd_i.clr_step;
  assign pg_waddr = cmd_i.clr_step ? clr_q
                  : (PG_AW'(in_seg_slot) * PG_STRIDE + PG_AW'(in_page_slot));
  assign pg_wdata = cmd_i.clr_step ? '{valid: 1'b0, page: in_page_id, frame: in_frame_id}
                  : '{valid: in_entry_valid, page: in_page_id, frame: in_frame_id};
  assign pg_raddr = PG_AW'(seg_sel_q) * PG_STRIDE + PG_AW'(rd_cnt_q[PSL_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + PG_AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pg_we) begin
      pg_mem[pg_waddr] <= pg_wdata;
    end
    if (rd_en && pg_phase_q) begin
      pg_rd_q <= pg_mem[pg_raddr];
    end
  end

  // frame base of the matching page
  logic [31:0] fbase_q;
  logic [31:0] fbase_d;
  logic [5:0]  fshift;

  assign fshift  = spat_pkg::PAGE_KB_SHIFT + {1'b0, pg};
  assign fbase_d = {10'd0, pg_rd_q.frame} << fshift;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pg_take) begin
      fbase_q <= fbase_d;
    end
  end

  // output register
  logic                            out_valid_q;
  logic [spat_pkg::M_TDATA_W-1:0]  out_data_q;
  logic [spat_pkg::M_TUSER_W-1:0]  out_user_q;
  logic [31:0]                     phys;

  assign phys = fbase_q + poff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_user_q <= cmd_i.status;
      unique case (cmd_i.status)
        spat_pkg::ST_OK: begin
          out_data_q <= {6'd0, phys, fbase_q, poff, pfield, soff, sfield};
        end
        spat_pkg::ST_SEG_FAULT, spat_pkg::ST_PAGE_FAULT: begin
          out_data_q <= {6'd0, 32'd0, 32'd0, poff, pfield, soff, sfield};
        end
        default: begin
          out_data_q <= '0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

  // status to the controller
  always_comb begin
    sts_o            = '0;
    sts_o.clr_last   = (clr_q == CLR_LAST);
    sts_o.in_xlate   = (in_user_i == spat_pkg::FN_XLATE);
    sts_o.cmp_vld    = cmp_vld_q;
    sts_o.cmp_last   = pg_phase_q ? (cmp_idx_q == PG_LAST) : (cmp_idx_q == SEG_LAST);
    sts_o.seg_hit    = seg_vld_q[cmp_idx_q[SEG_AW-1:0]] && (seg_rd_q.num == sfield);
    sts_o.seg_len_ok = (soff < seg_rd_q.len);
    sts_o.pg_hit     = pg_rd_q.valid && (pg_rd_q.page == pfield);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

FILE: verif/tb_segmented_paged_address_translator_core.sv
// testbench for segmented_paged_address_translator_core: table writes and translations with
// an in-order result predictor held in a small scoreboard class; random stalls on both streams
// depends on spat_pkg and the translator core
module tb_segmented_paged_address_translator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SEGS     = spat_pkg::SEG_ENTRIES_DEF;
  localparam int PAGES_PER    = spat_pkg::PAGES_PER_SEG_DEF;
  localparam int PHASES       = 11;
  localparam int PHASE_ITEMS  = 150;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int MAX_PRINTED  = 40;

  // one input transaction, fields as the core sees them
  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  seg_slot;
    logic [5:0]  page_slot;
    logic        entry_valid;
    logic [11:0] seg_id;
    logic [31:0] seg_limit;
    logic [21:0] page_id;
    logic [21:0] frame_id;
    logic [31:0] logical_addr;
  } xlat_req_t;

  // one result transaction
  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] seg_field;
    logic [31:0] seg_offset;
    logic [21:0] page_field;
    logic [31:0] page_offset;
    logic [31:0] frame_base;
    logic [31:0] phys_addr;
  } xlat_rsp_t;

  // shadow tables, register copies and the queue of results still due
  class xlat_scoreboard;
    bit          seg_v[NUM_SEGS];
    bit [11:0]   seg_num[NUM_SEGS];
    bit [31:0]   seg_len[NUM_SEGS];
    bit          pg_v[NUM_SEGS*PAGES_PER];
    bit [21:0]   pg_num[NUM_SEGS*PAGES_PER];
    bit [21:0]   pg_frame[NUM_SEGS*PAGES_PER];
    bit [3:0]    seg_cfg = 4'd0;
    bit [4:0]    page_cfg = 5'd2;
    xlat_rsp_t   awaited[$];
    int          errors;
    int          checked;

    function bit [63:0] low_mask(int unsigned n);
      return (64'd1 << n) - 64'd1;
    endfunction

    function int unsigned page_log2();
      return (page_cfg > 5'd22) ? 22 : page_cfg;
    endfunction

    function int unsigned seg_bits();
      return 12 - ((seg_cfg > 4'd12) ? 12 : seg_cfg);
    endfunction

    function int unsigned page_bits();
      int unsigned sbits;
      sbits = seg_bits();
      return (sbits + page_log2() >= 22) ? 0 : 22 - sbits - page_log2();
    endfunction

    function void apply_config(logic [spat_pkg::CFG_IDX_W-1:0] idx,
                               logic [spat_pkg::CFG_DATA_W-1:0] val);
      if (idx == spat_pkg::CFG_SEG_SIZE) seg_cfg = val[3:0];
      else if (idx == spat_pkg::CFG_PAGE_SIZE) page_cfg = val[4:0];
    endfunction

    // work out the result of one accepted transaction and update the tables
    function void predict_xlat(xlat_req_t r);
      xlat_rsp_t   e;
      int unsigned sbits, obits, pg, hit, ix, i;
      bit [63:0]   a, t, soff, poff, fbase;
      bit          found;
      e = '0;
      e.status = spat_pkg::ST_WRITE_DONE;
      case (r.func)
        spat_pkg::FN_SEG_WR: begin
          if (r.seg_slot < NUM_SEGS) begin
            seg_v[r.seg_slot]   = r.entry_valid;
            seg_num[r.seg_slot] = r.seg_id;
            seg_len[r.seg_slot] = r.seg_limit;
          end
        end
        spat_pkg::FN_PG_WR: begin
          if (r.seg_slot < NUM_SEGS && r.page_slot < PAGES_PER) begin
            ix = r.seg_slot * PAGES_PER + r.page_slot;
            pg_v[ix]     = r.entry_valid;
            pg_num[ix]   = r.page_id;
            pg_frame[ix] = r.frame_id;
          end
        end
        spat_pkg::FN_XLATE: begin
          pg    = page_log2();
          sbits = seg_bits();
          obits = 32 - sbits - page_bits();
          a     = {32'd0, r.logical_addr};
          t     = a >> (32 - sbits);
          e.seg_field = t[11:0];
          soff  = a & low_mask(32 - sbits);
          e.seg_offset = soff[31:0];
          t     = soff >> obits;
          e.page_field = t[21:0];
          poff  = a & low_mask(obits);
          e.page_offset = poff[31:0];
          // first valid segment slot with a matching number wins
          found = 1'b0;
          hit   = 0;
          for (i = 0; i < NUM_SEGS; i++) begin
            if (!found && seg_v[i] && seg_num[i] == e.seg_field) begin
              found = 1'b1;
              hit   = i;
            end
          end
          if (!found || soff >= {32'd0, seg_len[hit]}) begin
            e.status = spat_pkg::ST_SEG_FAULT;
          end else begin
            found = 1'b0;
            ix    = 0;
            for (i = 0; i < PAGES_PER; i++) begin
              if (!found && pg_v[hit*PAGES_PER + i] &&
                  pg_num[hit*PAGES_PER + i] == e.page_field) begin
                found = 1'b1;
                ix    = hit * PAGES_PER + i;
              end
            end
            if (!found) begin
              e.status = spat_pkg::ST_PAGE_FAULT;
            end else begin
              // frame base wraps at 32 bits
              fbase = ({42'd0, pg_frame[ix]} << (10 + pg)) & 64'hFFFF_FFFF;
              t     = fbase + poff;
              e.status     = spat_pkg::ST_OK;
              e.frame_base = fbase[31:0];
              e.phys_addr  = t[31:0];
            end
          end
        end
        default: ;
      endcase
      awaited.push_back(e);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= MAX_PRINTED)
        $display("[%0t] result %0d %s: got 0x%0h, want 0x%0h", $time, checked, what, got, want);
    endtask

    // compare one accepted result with the oldest result due
    task check_xlat(logic [spat_pkg::M_TUSER_W-1:0] st, logic [spat_pkg::M_TDATA_W-1:0] d);
      xlat_rsp_t g;
      xlat_rsp_t e;
      if (awaited.size() == 0) begin
        report_mismatch("unexpected result", {30'd0, st}, 32'd0);
        return;
      end
      e = awaited.pop_front();
      g.status      = st[1:0];
      g.seg_field   = d[11:0];
      g.seg_offset  = d[43:12];
      g.page_field  = d[65:44];
      g.page_offset = d[97:66];
      g.frame_base  = d[129:98];
      g.phys_addr   = d[161:130];
      if (g.status !== e.status) report_mismatch("status", 32'(g.status), 32'(e.status));
      if (g.seg_field !== e.seg_field)
        report_mismatch("seg_field", 32'(g.seg_field), 32'(e.seg_field));
      if (g.seg_offset !== e.seg_offset)
        report_mismatch("seg_offset", g.seg_offset, e.seg_offset);
      if (g.page_field !== e.page_field)
        report_mismatch("page_field", 32'(g.page_field), 32'(e.page_field));
      if (g.page_offset !== e.page_offset)
        report_mismatch("page_offset", g.page_offset, e.page_offset);
      if (g.frame_base !== e.frame_base)
        report_mismatch("frame_base", g.frame_base, e.frame_base);
      if (g.phys_addr !== e.phys_addr) report_mismatch("phys_addr", g.phys_addr, e.phys_addr);
      checked++;
    endtask
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [spat_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [spat_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [spat_pkg::S_TDATA_W-1:0]  s_tdata;
  logic [spat_pkg::S_TUSER_W-1:0]  s_tuser;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [spat_pkg::M_TDATA_W-1:0]  m_tdata;
  logic [spat_pkg::M_TUSER_W-1:0]  m_tuser;

  xlat_scoreboard sb;
  bit             quiet;
  int unsigned    out_hold;
  int unsigned    cycles;
  xlat_req_t      directed[$];
  int             seg_list[9]  = '{0, 12, 0, 12, 15, 6, 3, 9, 13};
  int             page_list[9] = '{2, 22, 0, 0, 31, 10, 4, 23, 1};

  segmented_paged_address_translator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    // seg_slot page_slot entry_valid seg_id seg_limit page_id frame_id logical_addr
    .s_axis_tdata_i  (s_tdata),
    // func
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    // seg_field seg_offset page_field page_offset frame_base phys_addr
    .m_axis_tdata_o  (m_tdata),
    // status
    .m_axis_tuser_o  (m_tuser)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_segmented_paged_address_translator_core: done, errors");
      $finish;
    end
  end

  // idle lengths: mostly short, a few long, none in a quiet phase
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet) return 0;
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    if (roll < 97) return $urandom_range(5, 20);
    return $urandom_range(40, 120);
  endfunction

  // result side back-pressure
  initial begin
    m_tready = 1'b0;
    out_hold = 0;
    forever begin
      @(negedge clk_i);
      if (out_hold > 0) begin
        m_tready <= 1'b0;
        out_hold--;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_hold = pick_gap();
      end
    end
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) sb.check_xlat(m_tuser, m_tdata);
  end

  function automatic xlat_req_t req(logic [1:0] fn, logic [3:0] sslot, logic [5:0] pslot,
                                    logic v, logic [11:0] sid, logic [31:0] lim,
                                    logic [21:0] pid, logic [21:0] fid, logic [31:0] addr);
    xlat_req_t r;
    r = '{fn, sslot, pslot, v, sid, lim, pid, fid, addr};
    return r;
  endfunction

  function automatic int pick_valid_seg();
    int unsigned start, k;
    start = $urandom_range(0, NUM_SEGS - 1);
    for (k = 0; k < NUM_SEGS; k++)
      if (sb.seg_v[(start + k) % NUM_SEGS]) return (start + k) % NUM_SEGS;
    return -1;
  endfunction

  function automatic int pick_valid_page(int s);
    int unsigned start, k;
    start = $urandom_range(0, PAGES_PER - 1);
    for (k = 0; k < PAGES_PER; k++)
      if (sb.pg_v[s*PAGES_PER + (start + k) % PAGES_PER]) return (start + k) % PAGES_PER;
    return -1;
  endfunction

  // random transaction; most translations are built from live table entries
  function automatic xlat_req_t make_req(bit setup);
    xlat_req_t   r;
    logic [1:0]  fn;
    int unsigned roll, sbits, pbits, obits;
    int          s, p;
    bit [63:0]   m, a, sf, pf, off;
    r = req(spat_pkg::FN_NOP, 4'($urandom), 6'($urandom), 1'($urandom), 12'($urandom),
            $urandom, 22'($urandom), 22'($urandom), $urandom);
    sbits = sb.seg_bits();
    pbits = sb.page_bits();
    obits = 32 - sbits - pbits;
    roll  = $urandom_range(0, 99);
    if (setup) fn = (roll < 40) ? spat_pkg::FN_SEG_WR : spat_pkg::FN_PG_WR;
    else if (roll < 15) fn = spat_pkg::FN_SEG_WR;
    else if (roll < 40) fn = spat_pkg::FN_PG_WR;
    else if (roll < 95) fn = spat_pkg::FN_XLATE;
    else fn = spat_pkg::FN_NOP;
    r.func = fn;
    case (fn)
      spat_pkg::FN_SEG_WR: begin
        r.entry_valid = ($urandom_range(0, 99) < 85);
        m = sb.low_mask(sbits);
        if ($urandom_range(0, 99) < 80) r.seg_id = r.seg_id & m[11:0];
        roll = $urandom_range(0, 99);
        m = sb.low_mask(32 - sbits);
        if (roll < 45) r.seg_limit = 32'hFFFF_FFFF;
        else if (roll < 65) r.seg_limit = r.seg_limit & m[31:0];
        else if (roll < 85) r.seg_limit = $urandom_range(0, 4096);
      end
      spat_pkg::FN_PG_WR: begin
        s = pick_valid_seg();
        if (s >= 0 && $urandom_range(0, 99) < 75) r.seg_slot = 4'(s);
        r.entry_valid = ($urandom_range(0, 99) < 85);
        m = sb.low_mask(pbits);
        if ($urandom_range(0, 99) < 80) r.page_id = r.page_id & m[21:0];
      end
      spat_pkg::FN_XLATE: begin
        s = pick_valid_seg();
        if (s >= 0 && $urandom_range(0, 99) < 70) begin
          sf  = {52'd0, sb.seg_num[s]};
          p   = pick_valid_page(s);
          pf  = (p >= 0) ? {42'd0, sb.pg_num[s*PAGES_PER + p]} : {32'd0, $urandom};
          off = {32'd0, $urandom};
          roll = $urandom_range(0, 99);
          if (roll < 8) off = '1;
          else if (roll < 16) off = '0;
          a = (sf << (32 - sbits)) | ((pf & sb.low_mask(pbits)) << obits) |
              (off & sb.low_mask(obits));
          r.logical_addr = a[31:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // drive one transaction and wait for its handshake
  task automatic send_req(xlat_req_t r);
    int unsigned gap;
    logic [spat_pkg::S_TDATA_W-1:0] d;
    gap = pick_gap();
    d = '0;
    d[3:0]    = r.seg_slot;
    d[9:4]    = r.page_slot;
    d[10]     = r.entry_valid;
    d[22:11]  = r.seg_id;
    d[54:23]  = r.seg_limit;
    d[76:55]  = r.page_id;
    d[98:77]  = r.frame_id;
    d[130:99] = r.logical_addr;
    @(negedge clk_i);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.func;
    s_tdata  <= d;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sb.predict_xlat(r);
  endtask

  // hold off the sender until every result has come back
  task automatic drain(int unsigned settle);
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [spat_pkg::CFG_IDX_W-1:0] idx,
                           logic [spat_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    sb.apply_config(idx, val);
  endtask

  // main sequence
  initial begin
    int          ph, n;
    int unsigned seg_v, page_v;
    bit          top_bit;
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    quiet     = 1'b0;
    sb = new;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part at the reset split: 12 segment bits, 8 page bits, 12 offset bits
    // empty tables, then a no-op with every field at its top value
    directed.push_back(req(spat_pkg::FN_XLATE, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0000));
    directed.push_back(req(spat_pkg::FN_XLATE, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    directed.push_back(req(spat_pkg::FN_NOP, 4'hF, 6'h3F, 1, 12'hFFF, 32'hFFFF_FFFF,
                           22'h3FFFFF, 22'h3FFFFF, 32'hFFFF_FFFF));
    // top segment twice, the lower slot wins; top page with a frame that wraps
    directed.push_back(req(spat_pkg::FN_SEG_WR, 0, 0, 1, 12'hFFF, 32'hFFFF_FFFF, 0, 0, 0));
    directed.push_back(req(spat_pkg::FN_SEG_WR, 15, 0, 1, 12'hFFF, 32'h0, 0, 0, 0));
    directed.push_back(req(spat_pkg::FN_PG_WR, 0, 63, 1, 0, 0, 22'h0000FF, 22'h3FFFFF, 0));
    directed.push_back(req(spat_pkg::FN_XLATE, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    // invalid page entry does not match
    directed.push_back(req(spat_pkg::FN_PG_WR, 0, 0, 0, 0, 0, 22'h0, 22'h1, 0));
    directed.push_back(req(spat_pkg::FN_XLATE, 0, 0, 0, 0, 0, 0, 0, 32'hFFF0_0123));
    // offset at the segment length faults, just below it reaches the page table
    directed.push_back(req(spat_pkg::FN_SEG_WR, 1, 0, 1, 12'h000, 32'h0000_1000, 0, 0, 0));
    directed.push_back(req(spat_pkg::FN_XLATE, 0, 0, 0, 0, 0, 0, 0, 32'h0000_1000));
    directed.push_back(req(spat_pkg::FN_XLATE, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0FFF));
    directed.push_back(req(spat_pkg::FN_PG_WR, 1, 5, 1, 0, 0, 22'h0, 22'h2AAAAA, 0));
    directed.push_back(req(spat_pkg::FN_XLATE, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0ABC));
    // invalid segment entry, then a valid one of zero length
    directed.push_back(req(spat_pkg::FN_SEG_WR, 2, 0, 0, 12'h005, 32'hFFFF_FFFF, 0, 0, 0));
    directed.push_back(req(spat_pkg::FN_XLATE, 0, 0, 0, 0, 0, 0, 0, 32'h0050_0000));
    directed.push_back(req(spat_pkg::FN_SEG_WR, 3, 0, 1, 12'h005, 32'h0, 0, 0, 0));
    directed.push_back(req(spat_pkg::FN_XLATE, 0, 0, 0, 0, 0, 0, 0, 32'h0050_0000));
    // duplicate page number in a lower slot takes over
    directed.push_back(req(spat_pkg::FN_PG_WR, 0, 1, 1, 0, 0, 22'h0000FF, 22'h000001, 0));
    directed.push_back(req(spat_pkg::FN_XLATE, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_F000));
    // clearing a page entry turns a hit into a page fault
    directed.push_back(req(spat_pkg::FN_PG_WR, 1, 5, 0, 0, 0, 22'h0, 22'h2AAAAA, 0));
    directed.push_back(req(spat_pkg::FN_XLATE, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0ABC));
    foreach (directed[i]) send_req(directed[i]);
    drain(10);

    // random phases over several address splits, extremes and clamped values included
    for (ph = 0; ph < PHASES; ph++) begin
      quiet   = (ph == 3);
      seg_v   = (ph < 9) ? seg_list[ph] : $urandom_range(0, 15);
      page_v  = (ph < 9) ? page_list[ph] : $urandom_range(0, 31);
      top_bit = 1'($urandom);
      write_reg(spat_pkg::CFG_SEG_SIZE, {top_bit, seg_v[3:0]});
      write_reg(spat_pkg::CFG_PAGE_SIZE, page_v[4:0]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n > 30 && $urandom_range(0, 99) == 0) drain(10);
        send_req(make_req(n < 25));
      end
      drain(10);
    end

    drain(100);
    if (sb.errors == 0 && sb.awaited.size() == 0)
      $display("tb_segmented_paged_address_translator_core: done, clean");
    else
      $display("tb_segmented_paged_address_translator_core: done, errors");
    $finish;
  end

endmodule
